FILE: rtl/core/dapid_pkg.sv
// Shared types and constants for the dual-axis incremental PID controller.
package dapid_pkg;

	// Fixed field widths
	localparam int GAIN_W = 16;
	localparam int TGT_W  = 16;
	localparam int CFG_W  = 16;
	localparam int ACC_W  = 32;
	localparam int IDX_W  = 3;

	// Position setpoint out of reset
	localparam logic signed [TGT_W-1:0] TARGET_POS_RST = 16'sd12;

	// Configuration register map
	typedef enum logic [IDX_W-1:0] {
		REG_KP_POS  = 3'd0,
		REG_KI_POS  = 3'd1,
		REG_KD_POS  = 3'd2,
		REG_KP_ANG  = 3'd3,
		REG_KI_ANG  = 3'd4,
		REG_KD_ANG  = 3'd5,
		REG_TGT_POS = 3'd6,
		REG_TGT_ANG = 3'd7
	} reg_idx_t;

	// Per-stage load strobes of the pipeline
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_out;
	} pipe_en_t;

endpackage

FILE: rtl/core/dapid_err.sv
// Error formation, error history and difference terms for both axes (stage 2).
module dapid_err
	import dapid_pkg::*;
#(
	parameter int SW = 16,
	parameter int EW = 18
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pipe_en_t                pe,
	input  logic signed [SW-1:0]    sens_one_s1,
	input  logic signed [SW-1:0]    sens_two_s1,
	input  logic signed [TGT_W-1:0] tgt_pos,
	input  logic signed [TGT_W-1:0] tgt_ang,
	output logic signed [EW-1:0]    err_pos_s2,
	output logic signed [EW:0]      d1_pos_s2,
	output logic signed [EW+1:0]    d2_pos_s2,
	output logic signed [EW-1:0]    err_ang_s2,
	output logic signed [EW:0]      d1_ang_s2,
	output logic signed [EW+1:0]    d2_ang_s2
);

	localparam int D1W = EW + 1;
	localparam int D2W = EW + 2;

	logic signed [SW:0]     sum;
	logic signed [SW-1:0]   pos;
	logic signed [SW:0]     ang;
	logic signed [EW-1:0]   err_pos;
	logic signed [EW-1:0]   err_ang;
	logic signed [EW-1:0]   last_pos_q, older_pos_q;
	logic signed [EW-1:0]   last_ang_q, older_ang_q;
	logic signed [D1W-1:0]  d1_pos, d1_ang;
	logic signed [D2W-1:0]  d2_pos, d2_ang;

	// Measurements: floor average and difference
	assign sum = (SW+1)'(sens_one_s1) + (SW+1)'(sens_two_s1);
	assign pos = sum[SW:1];
	assign ang = (SW+1)'(sens_one_s1) - (SW+1)'(sens_two_s1);

	assign err_pos = EW'(tgt_pos) - EW'(pos);
	assign err_ang = EW'(tgt_ang) - EW'(ang);

	// e - e1 and e - 2*e1 + e2
	assign d1_pos = D1W'(err_pos) - D1W'(last_pos_q);
	assign d1_ang = D1W'(err_ang) - D1W'(last_ang_q);
	assign d2_pos = D2W'(err_pos) - (D2W'(last_pos_q) <<< 1) + D2W'(older_pos_q);
	assign d2_ang = D2W'(err_ang) - (D2W'(last_ang_q) <<< 1) + D2W'(older_ang_q);

	// Error history shifts when a beat enters stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q  <= '0;
			older_pos_q <= '0;
			last_ang_q  <= '0;
			older_ang_q <= '0;
		end else if (pe.ld_s2) begin
			older_pos_q <= last_pos_q;
			last_pos_q  <= err_pos;
			older_ang_q <= last_ang_q;
			last_ang_q  <= err_ang;
		end
	end

	// Difference terms
	always_ff @(posedge clk) begin
		if (pe.ld_s2) begin
			d1_pos_s2 <= d1_pos;
			d2_pos_s2 <= d2_pos;
			d1_ang_s2 <= d1_ang;
			d2_ang_s2 <= d2_ang;
		end
	end

	// The newest error is the head of the history
	assign err_pos_s2 = last_pos_q;
	assign err_ang_s2 = last_ang_q;

endmodule

FILE: rtl/core/dapid_axis.sv
// One PID axis: gain products, increment and saturating accumulator.
module dapid_axis
	import dapid_pkg::*;
#(
	parameter int EW   = 18,
	parameter int FRAC = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pipe_en_t                 pe,
	input  logic signed [GAIN_W-1:0] kp,
	input  logic signed [GAIN_W-1:0] ki,
	input  logic signed [GAIN_W-1:0] kd,
	input  logic signed [EW-1:0]     err_s2,
	input  logic signed [EW:0]       d1_s2,
	input  logic signed [EW+1:0]     d2_s2,
	output logic signed [ACC_W-1:0]  acc
);

	localparam int PW   = GAIN_W + EW + 2;
	localparam int RW   = PW + 2;
	localparam int IW   = RW - FRAC;
	localparam int SUMW = ((IW > ACC_W) ? IW : ACC_W) + 1;

	logic signed [PW-1:0]    prod_p, prod_i, prod_d;
	logic signed [PW-1:0]    prod_p_s3, prod_i_s3, prod_d_s3;
	logic signed [RW-1:0]    raw;
	logic signed [IW-1:0]    inc_s4;
	logic signed [SUMW-1:0]  sum;
	logic                    fits;
	logic signed [ACC_W-1:0] acc_nxt;
	logic signed [ACC_W-1:0] acc_q;

	// Stage 3: three gain products
	assign prod_p = kp * d1_s2;
	assign prod_i = ki * err_s2;
	assign prod_d = kd * d2_s2;

	always_ff @(posedge clk) begin
		if (pe.ld_s3) begin
			prod_p_s3 <= prod_p;
			prod_i_s3 <= prod_i;
			prod_d_s3 <= prod_d;
		end
	end

	// Stage 4: sum, then floor shift out of fixed point
	assign raw = RW'(prod_p_s3) + RW'(prod_i_s3) + RW'(prod_d_s3);

	always_ff @(posedge clk) begin
		if (pe.ld_s4) begin
			inc_s4 <= raw[RW-1:FRAC];
		end
	end

	// Accumulate and clamp to the 32-bit range
	assign sum  = SUMW'(acc_q) + SUMW'(inc_s4);
	assign fits = (&sum[SUMW-1:ACC_W-1]) || !(|sum[SUMW-1:ACC_W-1]);

	always_comb begin
		if (fits) begin
			acc_nxt = sum[ACC_W-1:0];
		end else if (sum[SUMW-1]) begin
			acc_nxt = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			acc_nxt = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	// Accumulator doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (pe.ld_out) begin
			acc_q <= acc_nxt;
		end
	end

	assign acc = acc_q;

endmodule

FILE: rtl/core/dual_axis_incremental_pid.sv
// Dual-axis incremental PID controller: top level, configuration and pipeline control.
// An accepted beat goes from the input register through stages 2 to 4 to the result.
// Throughput: one beat per cycle unless out_ready stalls; add/clamp is combinational.
// Stages: input register, errors and differences, products, increment, accumulator.
// Reset clears gains, setpoints (position setpoint 12), error history,
// accumulators and all valid flags at once; no clearing pass.
module dual_axis_incremental_pid
	import dapid_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sensor_one,
	input  logic signed [SAMPLE_WIDTH-1:0] sensor_two,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [ACC_W-1:0]        drive_position,
	output logic signed [ACC_W-1:0]        drive_angle,
	input  logic                           cfg_we,
	input  logic [IDX_W-1:0]               cfg_idx,
	input  logic [CFG_W-1:0]               cfg_data
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int EW = (((SW + 1) > TGT_W) ? (SW + 1) : TGT_W) + 1;

	logic signed [GAIN_W-1:0] kp_pos_q, ki_pos_q, kd_pos_q;
	logic signed [GAIN_W-1:0] kp_ang_q, ki_ang_q, kd_ang_q;
	logic signed [TGT_W-1:0]  tgt_pos_q, tgt_ang_q;

	logic signed [SW-1:0] sens_one_s1, sens_two_s1;
	logic                 vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q;
	logic                 en_s1, en_s2, en_s3, en_s4, en_out;
	pipe_en_t             pe;

	logic signed [EW-1:0] err_pos_s2, err_ang_s2;
	logic signed [EW:0]   d1_pos_s2, d1_ang_s2;
	logic signed [EW+1:0] d2_pos_s2, d2_ang_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_pos_q  <= '0;
			ki_pos_q  <= '0;
			kd_pos_q  <= '0;
			kp_ang_q  <= '0;
			ki_ang_q  <= '0;
			kd_ang_q  <= '0;
			tgt_pos_q <= TARGET_POS_RST;
			tgt_ang_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_KP_POS:  kp_pos_q  <= cfg_data;
				REG_KI_POS:  ki_pos_q  <= cfg_data;
				REG_KD_POS:  kd_pos_q  <= cfg_data;
				REG_KP_ANG:  kp_ang_q  <= cfg_data;
				REG_KI_ANG:  ki_ang_q  <= cfg_data;
				REG_KD_ANG:  kd_ang_q  <= cfg_data;
				REG_TGT_POS: tgt_pos_q <= cfg_data;
				REG_TGT_ANG: tgt_ang_q <= cfg_data;
			endcase
		end
	end

	// Stall chain: a stage moves when it is empty or the next one moves
	assign en_out = !out_vld_q || out_ready;
	assign en_s4  = !vld_s4 || en_out;
	assign en_s3  = !vld_s3 || en_s4;
	assign en_s2  = !vld_s2 || en_s3;
	assign en_s1  = !vld_s1 || en_s2;

	assign pe.ld_s2  = vld_s1 && en_s2;
	assign pe.ld_s3  = vld_s2 && en_s3;
	assign pe.ld_s4  = vld_s3 && en_s4;
	assign pe.ld_out = vld_s4 && en_out;

	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (en_s1)  vld_s1    <= in_valid;
			if (en_s2)  vld_s2    <= vld_s1;
			if (en_s3)  vld_s3    <= vld_s2;
			if (en_s4)  vld_s4    <= vld_s3;
			if (en_out) out_vld_q <= vld_s4;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (in_valid && en_s1) begin
			sens_one_s1 <= sensor_one;
			sens_two_s1 <= sensor_two;
		end
	end

	dapid_err #(
		.SW (SW),
		.EW (EW)
	) u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.pe          (pe),
		.sens_one_s1 (sens_one_s1),
		.sens_two_s1 (sens_two_s1),
		.tgt_pos     (tgt_pos_q),
		.tgt_ang     (tgt_ang_q),
		.err_pos_s2  (err_pos_s2),
		.d1_pos_s2   (d1_pos_s2),
		.d2_pos_s2   (d2_pos_s2),
		.err_ang_s2  (err_ang_s2),
		.d1_ang_s2   (d1_ang_s2),
		.d2_ang_s2   (d2_ang_s2)
	);

	dapid_axis #(
		.EW   (EW),
		.FRAC (GAIN_FRAC_BITS)
	) u_axis_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.pe     (pe),
		.kp     (kp_pos_q),
		.ki     (ki_pos_q),
		.kd     (kd_pos_q),
		.err_s2 (err_pos_s2),
		.d1_s2  (d1_pos_s2),
		.d2_s2  (d2_pos_s2),
		.acc    (drive_position)
	);

	dapid_axis #(
		.EW   (EW),
		.FRAC (GAIN_FRAC_BITS)
	) u_axis_ang (
		.clk    (clk),
		.arst_n (arst_n),
		.pe     (pe),
		.kp     (kp_ang_q),
		.ki     (ki_ang_q),
		.kd     (kd_ang_q),
		.err_s2 (err_ang_s2),
		.d1_s2  (d1_ang_s2),
		.d2_s2  (d2_ang_s2),
		.acc    (drive_angle)
	);

	assign out_valid = out_vld_q;

	// Accumulators move only when a beat lands in the result register
	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pe.ld_out |=> $stable(drive_position) && $stable(drive_angle))
		else $error("accumulator changed without a result load");

	// A stalled last stage keeps its beat
	a_s4_keep: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !en_out |=> vld_s4)
		else $error("stage 4 beat dropped under stall");

	// An accepted beat occupies the input stage
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted beat not captured");

	// A result load always leaves a valid result
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		pe.ld_out |=> out_valid)
		else $error("result load without valid");

endmodule
